// ----- src/bqf_pkg.sv -----
`default_nettype none

package bqf_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    // Five products summed: three guard bits
    localparam int ACC_BITS    = PROD_BITS + 3;
    localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

    // Register port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    // Register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_A0 = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd5;

    // Coefficient reset values (Q4.14)
    localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(16384);
    localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

    // Multiply-accumulate term order
    localparam logic [2:0] TERM_B0   = 3'd0;
    localparam logic [2:0] TERM_B1   = 3'd1;
    localparam logic [2:0] TERM_B2   = 3'd2;
    localparam logic [2:0] TERM_A1   = 3'd3;
    localparam logic [2:0] TERM_A2   = 3'd4;
    localparam logic [2:0] TERM_LAST = 3'd5;

    // Output limits
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0]        NEG_LIM_MAG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a0;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic                   done;
        logic                   ovf;
        logic [SAMPLE_BITS-1:0] quotient;
    } t_div_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ABS,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN
    } t_div_state;

endpackage

`default_nettype wire

// ----- src/biquad_iir_filter.sv -----
`default_nettype none

// Direct form I biquad: y = (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2) / a0, with Q1.15 samples
// and Q4.14 coefficients written over the APB-style port (b0, b1, b2, a0, a1, a2 at byte
// addresses 0x00..0x14). The sum is kept exact, divided by a0 with truncation toward zero and
// saturated to 16 bits; clipped flags saturation. With a0 zero the output is 0 and
// divide_fault is set. block_start clears the input and output history before its sample.
// One item at a time. The multiply-accumulate steps run the five terms through the shared
// 16x18 multiplier plus the last add; then the signs are taken, the divider spends one range
// check, 16 serial steps and a done step, and the output register is loaded. A quotient out
// of range skips the divider steps; with a0 zero the item goes straight to the output load.
// Input stall stays high while an item is in work and drops once the result is loaded, so
// the block takes no new sample before it is through with the last; a finished result waits
// in the output register until taken and holds off the loading of the next one.

module biquad_iir_filter
    import bqf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                          i_block_start,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_clipped,
    output logic                               o_divide_fault,
    // Register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]      paddr,
    input  wire logic [APB_DATA_BITS-1:0]      pwdata,
    output logic [APB_DATA_BITS-1:0]           prdata,
    output logic                               pready
);

    t_coefs                         s_coefs;
    t_div_sts                       s_div;
    t_state                         r_state;
    t_state                         n_state;

    logic [2:0]                     r_cnt;
    logic signed [SAMPLE_BITS-1:0]  r_x;
    logic signed [SAMPLE_BITS-1:0]  r_x1;
    logic signed [SAMPLE_BITS-1:0]  r_x2;
    logic signed [SAMPLE_BITS-1:0]  r_y1;
    logic signed [SAMPLE_BITS-1:0]  r_y2;
    logic signed [PROD_BITS-1:0]    r_prod;
    logic                           r_sub;
    logic signed [ACC_BITS-1:0]     r_acc;
    logic                           r_neg;
    logic signed [SAMPLE_BITS-1:0]  r_y;
    logic                           r_clip;
    logic                           r_fault;
    logic                           r_ovalid;
    logic signed [SAMPLE_BITS-1:0]  r_osample;
    logic                           r_oclip;
    logic                           r_ofault;

    logic                           s_accept;
    logic                           s_out_free;
    logic                           s_a0_zero;
    logic signed [COEF_BITS-1:0]    s_mcoef;
    logic signed [SAMPLE_BITS-1:0]  s_msmp;
    logic signed [ACC_BITS-1:0]     s_pext;
    logic [ACC_BITS-1:0]            s_acc_mag;
    logic [COEF_BITS-1:0]           s_a0_mag;
    logic                           s_div_start;
    logic                           s_res_neg;
    logic signed [SAMPLE_BITS-1:0]  s_res_y;
    logic                           s_res_clip;

    bqf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (s_coefs)
    );

    assign s_accept    = i_in_valid && !o_in_stall;
    assign s_out_free  = !r_ovalid || !i_out_stall;
    assign s_a0_zero   = s_coefs.a0 == COEF_ZERO;
    assign s_div_start = r_state == ST_ABS;

    // Magnitudes for the divider
    assign s_acc_mag = r_acc[ACC_BITS-1] ? ACC_BITS'(-r_acc) : ACC_BITS'(r_acc);
    assign s_a0_mag  = s_coefs.a0[COEF_BITS-1] ? COEF_BITS'(-s_coefs.a0)
                                               : COEF_BITS'(s_coefs.a0);

    bqf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_acc_mag),
        .i_divisor  (s_a0_mag),
        .o_sts      (s_div)
    );

    // Select the operands of the shared multiplier
    always_comb begin
        case (r_cnt)
            TERM_B0: begin s_mcoef = s_coefs.b0; s_msmp = r_x;  end
            TERM_B1: begin s_mcoef = s_coefs.b1; s_msmp = r_x1; end
            TERM_B2: begin s_mcoef = s_coefs.b2; s_msmp = r_x2; end
            TERM_A1: begin s_mcoef = s_coefs.a1; s_msmp = r_y1; end
            TERM_A2: begin s_mcoef = s_coefs.a2; s_msmp = r_y2; end
            default: begin s_mcoef = '0;         s_msmp = '0;   end
        endcase
    end

    assign s_pext = ACC_BITS'(r_prod);

    // Sign and saturate the quotient
    always_comb begin
        s_res_neg  = r_neg && (s_div.ovf || (s_div.quotient != '0));
        s_res_clip = 1'b0;
        if (s_div.ovf) begin
            s_res_clip = 1'b1;
            s_res_y    = s_res_neg ? SAMPLE_MIN : SAMPLE_MAX;
        end else if (s_res_neg) begin
            if (s_div.quotient > NEG_LIM_MAG) begin
                s_res_clip = 1'b1;
                s_res_y    = SAMPLE_MIN;
            end else begin
                s_res_y = SAMPLE_BITS'(-s_div.quotient);
            end
        end else begin
            if (s_div.quotient > SAMPLE_BITS'(SAMPLE_MAX)) begin
                s_res_clip = 1'b1;
                s_res_y    = SAMPLE_MAX;
            end else begin
                s_res_y = s_div.quotient;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = s_a0_zero ? ST_DONE : ST_MAC;
            end
            ST_MAC:  if (r_cnt == TERM_LAST) n_state = ST_ABS;
            ST_ABS:  n_state = ST_DIV;
            ST_DIV:  if (s_div.done) n_state = ST_DONE;
            ST_DONE: if (s_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

    // History: clear on reset and block start, shift when the result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (r_state == ST_IDLE && s_accept && i_block_start) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (r_state == ST_DONE && s_out_free) begin
            r_x2 <= r_x1;
            r_x1 <= r_x;
            r_y2 <= r_y1;
            r_y1 <= r_y;
        end
    end

    // Datapath: multiply one term a cycle, add the registered product the next
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    r_x     <= i_sample_in;
                    r_cnt   <= TERM_B0;
                    r_acc   <= '0;
                    r_y     <= '0;
                    r_clip  <= 1'b0;
                    r_fault <= s_a0_zero;
                end
            end
            ST_MAC: begin
                if (r_cnt != TERM_B0) begin
                    r_acc <= r_sub ? r_acc - s_pext : r_acc + s_pext;
                end
                r_prod <= s_mcoef * s_msmp;
                r_sub  <= r_cnt >= TERM_A1;
                r_cnt  <= r_cnt + 1'b1;
            end
            ST_ABS: begin
                r_neg <= r_acc[ACC_BITS-1] ^ s_coefs.a0[COEF_BITS-1];
            end
            ST_DIV: begin
                if (s_div.done) begin
                    r_y    <= s_res_y;
                    r_clip <= s_res_clip;
                end
            end
            default: ;
        endcase
    end

    // Output register: hold until taken, load when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && s_out_free) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && s_out_free) begin
            r_osample <= r_y;
            r_oclip   <= r_clip;
            r_ofault  <= r_fault;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sample_out   = r_osample;
    assign o_clipped      = r_oclip;
    assign o_divide_fault = r_ofault;

    // A zero divisor gives a plain zero result
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_fault |-> (o_sample_out == '0) && !o_clipped)
        else $error("divide fault result not zero");

    // A clipped result sits at one of the limits
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> (o_sample_out == SAMPLE_MAX) || (o_sample_out == SAMPLE_MIN))
        else $error("clipped result not at a limit");

    // Busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // The divider only finishes while the sequencer waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div.done |-> r_state == ST_DIV)
        else $error("divider done outside divide state");

endmodule

`default_nettype wire

// ----- src/bqf_cfg.sv -----
`default_nettype none

module bqf_cfg
    import bqf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output t_coefs                        o_coefs
);

    t_coefs                    r_coefs;
    logic [REG_IDX_BITS-1:0]   s_idx;
    logic                      s_wr;
    logic signed [COEF_BITS-1:0] s_wval;
    logic signed [COEF_BITS-1:0] s_rval;

    assign s_idx  = paddr[APB_ADDR_BITS-1:2];
    assign s_wr   = psel && penable && pwrite;
    assign s_wval = pwdata[COEF_BITS-1:0];
    assign pready = 1'b1;

    // Write coefficient registers; ignore addresses past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_ONE;
            r_coefs.b1 <= COEF_ZERO;
            r_coefs.b2 <= COEF_ZERO;
            r_coefs.a0 <= COEF_ONE;
            r_coefs.a1 <= COEF_ZERO;
            r_coefs.a2 <= COEF_ZERO;
        end else if (s_wr) begin
            unique case (s_idx)
                REG_B0:  r_coefs.b0 <= s_wval;
                REG_B1:  r_coefs.b1 <= s_wval;
                REG_B2:  r_coefs.b2 <= s_wval;
                REG_A0:  r_coefs.a0 <= s_wval;
                REG_A1:  r_coefs.a1 <= s_wval;
                REG_A2:  r_coefs.a2 <= s_wval;
                default: ;
            endcase
        end
    end

    // Read back, sign-extended
    always_comb begin
        unique case (s_idx)
            REG_B0:  s_rval = r_coefs.b0;
            REG_B1:  s_rval = r_coefs.b1;
            REG_B2:  s_rval = r_coefs.b2;
            REG_A0:  s_rval = r_coefs.a0;
            REG_A1:  s_rval = r_coefs.a1;
            REG_A2:  s_rval = r_coefs.a2;
            default: s_rval = '0;
        endcase
    end

    assign prdata  = APB_DATA_BITS'(s_rval);
    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// ----- src/bqf_div.sv -----
`default_nettype none

module bqf_div
    import bqf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [ACC_BITS-1:0]  i_dividend,
    input  wire logic [COEF_BITS-1:0] i_divisor,
    output t_div_sts                  o_sts
);

    t_div_state             r_state;
    t_div_state             n_state;
    logic [ACC_BITS-1:0]    r_rem;
    logic [ACC_BITS-1:0]    r_dsh;
    logic [SAMPLE_BITS-1:0] r_quo;
    logic [STEP_BITS-1:0]   r_step;
    logic                   r_done;
    logic                   r_ovf;
    logic                   s_big;
    logic                   s_fit;
    logic                   s_last;

    // Quotient needs more than SAMPLE_BITS bits when dividend >= divisor << SAMPLE_BITS
    assign s_big  = {1'b0, r_rem} >= {r_dsh, 1'b0};
    assign s_fit  = r_rem >= r_dsh;
    assign s_last = r_step == STEP_BITS'(SAMPLE_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE:  if (i_start) n_state = DV_CHECK;
            DV_CHECK: n_state = s_big ? DV_IDLE : DV_RUN;
            DV_RUN:   if (s_last) n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    // Done is a one-cycle pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == DV_CHECK) && s_big) || ((r_state == DV_RUN) && s_last);
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_rem <= i_dividend;
                    r_dsh <= ACC_BITS'(i_divisor) << (SAMPLE_BITS - 1);
                end
            end
            DV_CHECK: begin
                r_ovf  <= s_big;
                r_quo  <= '0;
                r_step <= '0;
            end
            DV_RUN: begin
                if (s_fit) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quo  <= {r_quo[SAMPLE_BITS-2:0], s_fit};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_sts.done     = r_done;
    assign o_sts.ovf      = r_ovf;
    assign o_sts.quotient = r_quo;

endmodule

`default_nettype wire
